### design/rtch_pkg.sv
// Shared types, constants and the micro-op decode for the ray/triangle hit block.
package rtch_pkg;

    localparam int COORD_BITS_DEF = 21;
    localparam int FIELD_W        = 63;
    localparam int VEC_W          = 22;   // coordinate difference
    localparam int PQ_W           = 45;   // cross product component
    localparam int HALF_W         = 22;   // low split of a cross component
    localparam int MUL_W          = 23;   // multiplier operand
    localparam int PROD_W         = 2 * MUL_W;
    localparam int ACC_W          = 70;   // dot product accumulator
    localparam int DIST_W         = 31;
    localparam int FRAC_W         = 16;
    localparam int IDX_W          = 10;
    localparam int COL_W          = 24;
    localparam int CFG_IDX_W      = 8;
    localparam int STEP_W         = 6;
    localparam int N_UOP          = 36;

    localparam logic [DIST_W-1:0]    DIST_MAX     = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0]    NEAR_RST     = DIST_W'(6554);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR     = CFG_IDX_W'(1);

    typedef struct packed {
        logic               new_ray;
        logic [FIELD_W-1:0] ray_origin;
        logic [FIELD_W-1:0] ray_direction;
        logic [FIELD_W-1:0] vertex_a;
        logic [FIELD_W-1:0] vertex_b;
        logic [FIELD_W-1:0] vertex_c;
        logic [IDX_W-1:0]   triangle_index;
        logic [COL_W-1:0]   triangle_color;
    } t_rtch_in;

    typedef struct packed {
        logic              hit;
        logic              any_hit;
        logic [DIST_W-1:0] nearest_distance;
        logic [IDX_W-1:0]  nearest_index;
        logic [COL_W-1:0]  nearest_color;
    } t_rtch_out;

    typedef enum logic [1:0] {A_D, A_S, A_E1, A_E2} t_asel;
    typedef enum logic [1:0] {B_E1, B_E2, B_P, B_Q} t_bsel;
    typedef enum logic [2:0] {
        DST_NONE, DST_P, DST_Q, DST_DET, DST_UN, DST_VN, DST_TN
    } t_dest;

    typedef struct packed {
        t_asel      asel;
        logic [1:0] ak;
        t_bsel      bsel;
        logic [1:0] bk;
        logic       hi;     // use high half of a cross component, weight 2^22
        logic       neg;
        logic       first;  // start a new sum
        t_dest      dest;
        logic [1:0] dk;
    } t_uop;

    // Steps 0..11: two products per cross component (p = d x e2, q = s x e1).
    // Steps 12..35: six products per dot (det, u, v, t numerators).
    function automatic t_uop uop_decode(input logic [STEP_W-1:0] step);
        t_uop              u;
        logic [2:0]        idx;
        logic [1:0]        comp;
        logic [1:0]        k1;
        logic [1:0]        k2;
        logic [STEP_W-1:0] j;
        logic [1:0]        dsel;
        logic [2:0]        r;
        u    = '0;
        idx  = step[3:1];
        comp = (idx < 3'd3) ? idx[1:0] : 2'(idx - 3'd3);
        k1   = 2'd0;
        k2   = 2'd1;
        j    = step - STEP_W'(12);
        dsel = 2'd0;
        r    = 3'd0;
        if (step < STEP_W'(12)) begin
            unique case (comp)
                2'd0: begin k1 = 2'd1; k2 = 2'd2; end
                2'd1: begin k1 = 2'd2; k2 = 2'd0; end
                default: begin k1 = 2'd0; k2 = 2'd1; end
            endcase
            u.asel  = (idx < 3'd3) ? A_D : A_S;
            u.bsel  = (idx < 3'd3) ? B_E2 : B_E1;
            u.first = !step[0];
            u.neg   = step[0];
            u.ak    = step[0] ? k2 : k1;
            u.bk    = step[0] ? k1 : k2;
            u.dest  = !step[0] ? DST_NONE : ((idx < 3'd3) ? DST_P : DST_Q);
            u.dk    = comp;
        end else begin
            if (j < STEP_W'(6)) begin
                dsel = 2'd0; r = j[2:0];
            end else if (j < STEP_W'(12)) begin
                dsel = 2'd1; r = 3'(j - STEP_W'(6));
            end else if (j < STEP_W'(18)) begin
                dsel = 2'd2; r = 3'(j - STEP_W'(12));
            end else begin
                dsel = 2'd3; r = 3'(j - STEP_W'(18));
            end
            u.ak    = r[2:1];
            u.bk    = r[2:1];
            u.hi    = r[0];
            u.first = (r == 3'd0);
            unique case (dsel)
                2'd0: begin u.asel = A_E1; u.bsel = B_P; end
                2'd1: begin u.asel = A_S;  u.bsel = B_P; end
                2'd2: begin u.asel = A_D;  u.bsel = B_Q; end
                default: begin u.asel = A_E2; u.bsel = B_Q; end
            endcase
            if (r == 3'd5) begin
                unique case (dsel)
                    2'd0: u.dest = DST_DET;
                    2'd1: u.dest = DST_UN;
                    2'd2: u.dest = DST_VN;
                    default: u.dest = DST_TN;
                endcase
            end
        end
        return u;
    endfunction

endpackage

### design/rtch_mac.sv
// Shared 23x23 signed multiplier with a shifted add/subtract accumulator.
module rtch_mac (
    input  logic                         i_clk,
    input  logic                         i_mul_en,
    input  logic                         i_acc_en,
    input  rtch_pkg::t_uop               i_uop,
    input  logic signed [rtch_pkg::VEC_W-1:0] i_a,
    input  logic signed [rtch_pkg::MUL_W-1:0] i_b,
    output logic signed [rtch_pkg::ACC_W-1:0] o_acc_next
);
    import rtch_pkg::*;

    logic signed [MUL_W-1:0]  a_ext;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  sum;

    assign a_ext = {i_a[VEC_W-1], i_a};

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= a_ext * i_b;
        end
    end

    always_comb begin
        term = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        if (i_uop.hi) begin
            term = term <<< HALF_W;
        end
        sum        = i_uop.first ? '0 : r_acc;
        o_acc_next = i_uop.neg ? (sum - term) : (sum + term);
    end

    always_ff @(posedge i_clk) begin
        if (i_acc_en) begin
            r_acc <= o_acc_next;
        end
    end

endmodule

### design/rtch_div.sv
// Restoring divider, one quotient bit a cycle: floor(num * 2^16 / den), known below 2^31.
module rtch_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rtch_pkg::ACC_W-1:0]    i_num,
    input  logic [rtch_pkg::ACC_W-1:0]    i_den,
    output logic                          o_done,
    output logic [rtch_pkg::DIST_W-1:0]   o_quot
);
    import rtch_pkg::*;

    localparam int HEAD = DIST_W - FRAC_W;

    logic [ACC_W-1:0]  r_rem;
    logic [ACC_W-1:0]  r_den;
    logic [DIST_W-1:0] r_nbits;
    logic [DIST_W-1:0] r_quot;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ACC_W:0]    trial;
    logic [ACC_W:0]    diff;
    logic              ge;

    assign trial = {r_rem, r_nbits[DIST_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = !diff[ACC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= ACC_W'(i_num >> HEAD);
            r_nbits <= {i_num[HEAD-1:0], {FRAC_W{1'b0}}};
            r_den   <= i_den;
            r_cnt   <= 5'(DIST_W - 1);
        end else if (r_busy) begin
            r_rem   <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
            r_nbits <= r_nbits << 1;
            r_quot  <= {r_quot[DIST_W-2:0], ge};
            r_cnt   <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### design/ray_triangle_closest_hit.sv
// Top level: sequencer, operand registers, nearest-hit state and handshakes.
// A zero determinant or a failed candidate check skips the divide and goes straight to the result.
// Throughput: one request at a time, the next taken once the result is registered; 36 products
// through one shared multiplier, each registered and then accumulated, then a bit-serial divide.
// Reset (synchronous, active low) clears the kept hit, sets max_distance to
// 0x7FFFFFFF and near_limit to 6554, and empties the result register.
module ray_triangle_closest_hit #(
    parameter int COORD_BITS = rtch_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  rtch_pkg::t_rtch_in              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output rtch_pkg::t_rtch_out             o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rtch_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtch_pkg::DIST_W-1:0]     i_cfg_data
);
    import rtch_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAC   = 6'b000010,
        ST_NORM  = 6'b000100,
        ST_CHECK = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic signed [VEC_W-1:0] r_d  [3];
    logic signed [VEC_W-1:0] r_s  [3];
    logic signed [VEC_W-1:0] r_e1 [3];
    logic signed [VEC_W-1:0] r_e2 [3];
    logic signed [PQ_W-1:0]  r_p  [3];
    logic signed [PQ_W-1:0]  r_q  [3];
    logic signed [ACC_W-1:0] r_det, r_un, r_vn, r_tn;
    logic [IDX_W-1:0]        r_idx;
    logic [COL_W-1:0]        r_col;
    logic [STEP_W-1:0]       r_step;
    logic                    r_phase;
    logic                    r_ok;
    logic [DIST_W-1:0]       r_t;

    logic [DIST_W-1:0]       r_max, r_near, r_best_dist;
    logic [IDX_W-1:0]        r_best_idx;
    logic [COL_W-1:0]        r_best_col;
    logic                    r_best_valid;
    logic                    r_out_valid;
    t_rtch_out               r_out;

    t_uop                    uop;
    logic signed [VEC_W-1:0] op_a;
    logic signed [MUL_W-1:0] op_b;
    logic signed [ACC_W-1:0] acc_next;
    logic                    mul_en, acc_en;
    logic                    in_acc, out_free, fin_go, hit_now;
    logic                    div_start, div_done;
    logic [DIST_W-1:0]       div_quot;
    logic signed [ACC_W:0]   uv_sum;
    logic signed [ACC_W+DIST_W-FRAC_W-1:0] det_lim;
    logic                    cand;

    function automatic logic signed [VEC_W-1:0] coord(input logic [FIELD_W-1:0] f,
                                                      input int k);
        logic [COORD_BITS-1:0] v;
        v = f[k*COORD_BITS +: COORD_BITS];
        return {{(VEC_W-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic logic signed [VEC_W-1:0] pick(input logic signed [VEC_W-1:0] v [3],
                                                     input logic [1:0] k);
        logic signed [VEC_W-1:0] r;
        unique case (k)
            2'd0: r = v[0];
            2'd1: r = v[1];
            default: r = v[2];
        endcase
        return r;
    endfunction

    function automatic logic signed [PQ_W-1:0] pick_pq(input logic signed [PQ_W-1:0] v [3],
                                                       input logic [1:0] k);
        logic signed [PQ_W-1:0] r;
        unique case (k)
            2'd0: r = v[0];
            2'd1: r = v[1];
            default: r = v[2];
        endcase
        return r;
    endfunction

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign fin_go   = (r_state == ST_FIN) && out_free;
    assign hit_now  = r_ok && (r_t >= r_near) && (r_t < r_best_dist);

    // operand selection for the shared multiplier
    assign uop    = uop_decode(r_step);
    assign mul_en = (r_state == ST_MAC) && !r_phase;
    assign acc_en = (r_state == ST_MAC) && r_phase;

    always_comb begin
        logic signed [PQ_W-1:0] w;
        unique case (uop.asel)
            A_D:  op_a = pick(r_d, uop.ak);
            A_S:  op_a = pick(r_s, uop.ak);
            A_E1: op_a = pick(r_e1, uop.ak);
            default: op_a = pick(r_e2, uop.ak);
        endcase
        w = (uop.bsel == B_P) ? pick_pq(r_p, uop.bk) : pick_pq(r_q, uop.bk);
        unique case (uop.bsel)
            B_E1: op_b = MUL_W'(pick(r_e1, uop.bk));
            B_E2: op_b = MUL_W'(pick(r_e2, uop.bk));
            default: op_b = uop.hi ? w[PQ_W-1:HALF_W] : {1'b0, w[HALF_W-1:0]};
        endcase
    end

    rtch_mac u_mac (
        .i_clk      (i_clk),
        .i_mul_en   (mul_en),
        .i_acc_en   (acc_en),
        .i_uop      (uop),
        .i_a        (op_a),
        .i_b        (op_b),
        .o_acc_next (acc_next)
    );

    // candidate test after the sign of det is folded in
    assign uv_sum  = {r_un[ACC_W-1], r_un} + {r_vn[ACC_W-1], r_vn};
    assign det_lim = {{(DIST_W-FRAC_W){r_det[ACC_W-1]}}, r_det} <<< (DIST_W - FRAC_W);
    assign cand    = !r_un[ACC_W-1] && !r_vn[ACC_W-1] && !r_tn[ACC_W-1]
                   && (r_un <= r_det)
                   && (uv_sum <= {r_det[ACC_W-1], r_det})
                   && ({{(DIST_W-FRAC_W){r_tn[ACC_W-1]}}, r_tn} < det_lim);
    assign div_start = (r_state == ST_CHECK) && cand;

    rtch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (ACC_W'(unsigned'(r_tn))),
        .i_den   (ACC_W'(unsigned'(r_det))),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_MAC;
            ST_MAC:   if (r_phase && r_step == STEP_W'(N_UOP - 1)) n_state = ST_NORM;
            ST_NORM:  n_state = (r_det == '0) ? ST_FIN : ST_CHECK;
            ST_CHECK: n_state = cand ? ST_DIV : ST_FIN;
            ST_DIV:   if (div_done) n_state = ST_FIN;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencing and working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k]  <= coord(i_in.ray_direction, k);
                r_s[k]  <= coord(i_in.ray_origin, k) - coord(i_in.vertex_a, k);
                r_e1[k] <= coord(i_in.vertex_b, k) - coord(i_in.vertex_a, k);
                r_e2[k] <= coord(i_in.vertex_c, k) - coord(i_in.vertex_a, k);
            end
            r_idx   <= i_in.triangle_index;
            r_col   <= i_in.triangle_color;
            r_step  <= '0;
            r_phase <= 1'b0;
            r_ok    <= 1'b0;
        end
        if (r_state == ST_MAC) begin
            r_phase <= !r_phase;
            if (r_phase) begin
                r_step <= r_step + STEP_W'(1);
                for (int k = 0; k < 3; k++) begin
                    if (uop.dk == 2'(k)) begin
                        if (uop.dest == DST_P) r_p[k] <= acc_next[PQ_W-1:0];
                        if (uop.dest == DST_Q) r_q[k] <= acc_next[PQ_W-1:0];
                    end
                end
                unique case (uop.dest)
                    DST_DET: r_det <= acc_next;
                    DST_UN:  r_un  <= acc_next;
                    DST_VN:  r_vn  <= acc_next;
                    DST_TN:  r_tn  <= acc_next;
                    default: ;
                endcase
            end
        end
        if (r_state == ST_NORM && r_det[ACC_W-1]) begin
            r_det <= -r_det;
            r_un  <= -r_un;
            r_vn  <= -r_vn;
            r_tn  <= -r_tn;
        end
        if (r_state == ST_DIV && div_done) begin
            r_t  <= div_quot;
            r_ok <= 1'b1;
        end
    end

    // configuration, kept hit and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= DIST_MAX;
            r_near       <= NEAR_RST;
            r_best_dist  <= DIST_MAX;
            r_best_idx   <= '0;
            r_best_col   <= '0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                priority if (i_cfg_index == CFG_MAX_DIST) r_max <= i_cfg_data;
                else if (i_cfg_index == CFG_NEAR) r_near <= i_cfg_data;
            end
            if (in_acc && i_in.new_ray) begin
                r_best_dist  <= r_max;
                r_best_idx   <= '0;
                r_best_col   <= '0;
                r_best_valid <= 1'b0;
            end
            if (fin_go) begin
                r_out_valid          <= 1'b1;
                r_out.hit            <= hit_now;
                r_out.any_hit        <= hit_now || r_best_valid;
                r_out.nearest_distance <= hit_now ? r_t : r_best_dist;
                r_out.nearest_index  <= hit_now ? r_idx : r_best_idx;
                r_out.nearest_color  <= hit_now ? r_col : r_best_col;
                if (hit_now) begin
                    r_best_dist  <= r_t;
                    r_best_idx   <= r_idx;
                    r_best_col   <= r_col;
                    r_best_valid <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("request taken while a test is in flight");

    a_hit_implies_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.hit) |-> o_out.any_hit)
        else $error("hit reported without any_hit");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_hit_keeps_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && hit_now) |=> (r_best_valid && r_best_dist == $past(r_t)))
        else $error("accepted hit not kept as nearest");

endmodule

### tb/sv/tb_ray_triangle_closest_hit.sv
// Testbench for ray_triangle_closest_hit: aimed and raw requests, scoreboard check.
module tb_ray_triangle_closest_hit;
    import rtch_pkg::*;

    typedef logic signed [127:0] wide_t;

    class hit_scoreboard;
        logic [DIST_W-1:0] max_dist, near_lim, best_dist;
        logic [IDX_W-1:0]  best_idx;
        logic [COL_W-1:0]  best_col;
        logic              best_ok;
        t_rtch_out         pending[$];
        int                errors, n_results, n_hits;

        function new();
            max_dist  = DIST_MAX;
            near_lim  = NEAR_RST;
            best_dist = DIST_MAX;
            best_idx  = '0;
            best_col  = '0;
            best_ok   = 1'b0;
            errors    = 0;
            n_results = 0;
            n_hits    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
            if (idx == CFG_MAX_DIST) max_dist = val;
            else if (idx == CFG_NEAR) near_lim = val;
        endfunction

        function longint coord(logic [FIELD_W-1:0] f, int k);
            return longint'($signed(f[k*21 +: 21]));
        endfunction

        function wide_t dot(longint a[3], longint b[3]);
            return wide_t'(a[0]) * wide_t'(b[0]) + wide_t'(a[1]) * wide_t'(b[1])
                 + wide_t'(a[2]) * wide_t'(b[2]);
        endfunction

        // Closest-hit update for one ray/triangle request
        function void note_request(t_rtch_in r);
            longint    o[3], d[3], e1[3], e2[3], s[3], p[3], q[3];
            wide_t     det, un, vn, tn, quo;
            t_rtch_out x;
            logic      took;
            took = 1'b0;
            if (r.new_ray) begin
                best_dist = max_dist;
                best_idx  = '0;
                best_col  = '0;
                best_ok   = 1'b0;
            end
            for (int k = 0; k < 3; k++) begin
                o[k]  = coord(r.ray_origin, k);
                d[k]  = coord(r.ray_direction, k);
                e1[k] = coord(r.vertex_b, k) - coord(r.vertex_a, k);
                e2[k] = coord(r.vertex_c, k) - coord(r.vertex_a, k);
                s[k]  = o[k] - coord(r.vertex_a, k);
            end
            p[0] = d[1]*e2[2] - d[2]*e2[1];
            p[1] = d[2]*e2[0] - d[0]*e2[2];
            p[2] = d[0]*e2[1] - d[1]*e2[0];
            q[0] = s[1]*e1[2] - s[2]*e1[1];
            q[1] = s[2]*e1[0] - s[0]*e1[2];
            q[2] = s[0]*e1[1] - s[1]*e1[0];
            det = dot(e1, p);
            if (det != 0) begin
                un = dot(s, p);
                vn = dot(d, q);
                tn = dot(e2, q);
                if (det < 0) begin
                    det = -det; un = -un; vn = -vn; tn = -tn;
                end
                if (un >= 0 && vn >= 0 && un <= det && un + vn <= det && tn >= 0) begin
                    quo = (tn <<< FRAC_W) / det;
                    if (quo > wide_t'(DIST_MAX)) quo = wide_t'(DIST_MAX);
                    if (quo >= wide_t'(near_lim) && quo < wide_t'(best_dist)) begin
                        best_dist = quo[DIST_W-1:0];
                        best_idx  = r.triangle_index;
                        best_col  = r.triangle_color;
                        best_ok   = 1'b1;
                        took      = 1'b1;
                    end
                end
            end
            x.hit              = took;
            x.any_hit          = best_ok;
            x.nearest_distance = best_dist;
            x.nearest_index    = best_idx;
            x.nearest_color    = best_col;
            pending.push_back(x);
        endfunction

        function void check_result(t_rtch_out got);
            t_rtch_out e;
            n_results++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.hit) n_hits++;
            if (got.hit !== e.hit) begin
                $display("%0t: hit exp %0b got %0b", $time, e.hit, got.hit);
                errors++;
            end
            if (got.any_hit !== e.any_hit) begin
                $display("%0t: any_hit exp %0b got %0b", $time, e.any_hit, got.any_hit);
                errors++;
            end
            if (got.nearest_distance !== e.nearest_distance) begin
                $display("%0t: distance exp %h got %h", $time,
                         e.nearest_distance, got.nearest_distance);
                errors++;
            end
            if (got.nearest_index !== e.nearest_index) begin
                $display("%0t: index exp %0d got %0d", $time,
                         e.nearest_index, got.nearest_index);
                errors++;
            end
            if (got.nearest_color !== e.nearest_color) begin
                $display("%0t: color exp %h got %h", $time,
                         e.nearest_color, got.nearest_color);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_rtch_in               i_in = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_rtch_out              o_out;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [DIST_W-1:0]      i_cfg_data = '0;

    hit_scoreboard sb = new();
    int  n_sent = 0;
    int  cycles = 0;
    bit  calm = 1'b0;   // no idling on either side
    bit  held = 1'b0;

    localparam int CYCLE_LIMIT = 3_000_000;

    ray_triangle_closest_hit u_top (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("tb_ray_triangle_closest_hit: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the input
    initial begin
        forever begin
            @(negedge i_clk);
            if (!held && n_sent >= 300) begin
                held = 1'b1;
                i_out_ready = 1'b0;
                repeat (600) @(negedge i_clk);
            end
            i_out_ready = calm ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);

    function automatic logic [FIELD_W-1:0] pack3(longint x, longint y, longint z);
        return {21'(z), 21'(y), 21'(x)};
    endfunction

    function automatic longint rnd(int span);
        return longint'($urandom_range(2*span)) - span;
    endfunction

    // Ray from a random origin aimed at a + (i*e1 + j*e2)/16, scaled by 2^-shift (by 2^4 if up), negated if flip
    function automatic t_rtch_in aimed(bit nr, int i, int j, int shift, bit flip, bit up);
        t_rtch_in r;
        longint a[3], b[3], c[3], o[3], d[3];
        for (int k = 0; k < 3; k++) begin
            a[k] = rnd(16384); b[k] = rnd(16384); c[k] = rnd(16384);
            o[k] = rnd(16384);
            d[k] = a[k] + ((b[k]-a[k])*i + (c[k]-a[k])*j) / 16 - o[k];
            d[k] = up ? (d[k] <<< 4) : (d[k] >>> shift);
            if (flip) d[k] = -d[k];
        end
        r.new_ray        = nr;
        r.ray_origin     = pack3(o[0], o[1], o[2]);
        r.ray_direction  = pack3(d[0], d[1], d[2]);
        r.vertex_a       = pack3(a[0], a[1], a[2]);
        r.vertex_b       = pack3(b[0], b[1], b[2]);
        r.vertex_c       = pack3(c[0], c[1], c[2]);
        r.triangle_index = IDX_W'($urandom);
        r.triangle_color = COL_W'($urandom);
        return r;
    endfunction

    function automatic t_rtch_in raw_item();
        t_rtch_in r;
        r.new_ray        = 1'($urandom_range(1));
        r.ray_origin     = FIELD_W'({$urandom, $urandom});
        r.ray_direction  = FIELD_W'({$urandom, $urandom});
        r.vertex_a       = FIELD_W'({$urandom, $urandom});
        r.vertex_b       = FIELD_W'({$urandom, $urandom});
        r.vertex_c       = FIELD_W'({$urandom, $urandom});
        r.triangle_index = IDX_W'($urandom);
        r.triangle_color = COL_W'($urandom);
        return r;
    endfunction

    task automatic send(t_rtch_in r);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 26) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in = r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
        n_sent++;
    endtask

    task automatic idle_out();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_phase(int n);
        t_rtch_in r;
        int sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 20) r = raw_item();
            else if (sel < 30) r = aimed($urandom_range(3) == 0, $urandom_range(16),
                                         0, $urandom_range(17, 15),
                                         $urandom_range(1) == 1, 0);
            else begin
                int i = $urandom_range(20);
                r = aimed($urandom_range(3) == 0, i, $urandom_range(20 - i),
                          $urandom_range(6), $urandom_range(9) == 0,
                          $urandom_range(9) == 0);
            end
            send(r);
        end
    endtask

    initial begin
        t_rtch_in r;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset registers
        r = '0;              send(r);   // degenerate, zero determinant
        r = '1;              send(r);
        r = '0; r.new_ray = 1'b1;
        r.ray_origin = {3{21'h0FFFFF}}; r.ray_direction = {3{21'h100000}};
        r.vertex_a = {3{21'h100000}}; r.vertex_b = {21'h0FFFFF, 21'h100000, 21'h0FFFFF};
        r.vertex_c = {21'h100000, 21'h0FFFFF, 21'h0FFFFF};
        r.triangle_index = '1; r.triangle_color = '1;
        send(r);
        send(aimed(1, 4, 4, 2, 0, 0));   // hit
        send(aimed(0, 5, 5, 3, 0, 0));   // farther, kept hit unchanged
        send(aimed(0, 5, 5, 0, 0, 0));   // closer
        send(aimed(0, 0, 0, 1, 0, 0));   // exactly on a corner
        send(aimed(0, 16, 0, 1, 0, 0));  // opposite corner, u = 1
        send(aimed(0, 8, 8, 1, 0, 0));   // on the far edge, u + v = 1
        send(aimed(0, 14, 8, 1, 0, 0));  // outside
        send(aimed(1, 4, 4, 1, 1, 0));   // triangle behind the ray
        send(aimed(1, 4, 4, 17, 0, 0));  // saturated distance
        send(aimed(1, 4, 4, 0, 0, 1));   // under near limit
        idle_out();

        write_cfg(CFG_NEAR, '0);
        write_cfg(CFG_MAX_DIST, DIST_MAX);
        write_cfg(CFG_IDX_W'(5), 31'h1234);   // unused index
        send(aimed(1, 4, 4, 0, 0, 1));
        send(aimed(0, 3, 3, 4, 0, 0));
        random_phase(450);
        calm = 1'b1;
        random_phase(200);
        calm = 1'b0;
        idle_out();

        write_cfg(CFG_MAX_DIST, '0);
        random_phase(60);
        idle_out();
        write_cfg(CFG_MAX_DIST, DIST_MAX);
        write_cfg(CFG_NEAR, DIST_MAX);
        random_phase(60);
        idle_out();
        write_cfg(CFG_MAX_DIST, 31'h0004_0000);
        write_cfg(CFG_NEAR, 31'h0000_8000);
        random_phase(700);
        idle_out();

        $display("covered %0d requests, %0d results, %0d nearest-hit updates",
                 n_sent, sb.n_results, sb.n_hits);
        $display("register settings: defaults, zero/full max distance, zero/full near limit");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_ray_triangle_closest_hit: done, clean");
        else
            $display("tb_ray_triangle_closest_hit: done, errors");
        $finish;
    end
endmodule
